>>> src/spq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY    = 64;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int VAL_W       = 32;
	localparam int PRIO_W      = 8;
	localparam int COUNT_OUT_W = 7;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [VAL_W-1:0]  value;
		logic [PRIO_W-1:0] prio;
	} cell_ctrl_t;

endpackage

>>> src/spq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds an entry, shifts left or right.
module spq_cell (
	input  logic                       clk,
	input  logic                       entry_valid,
	input  spq_pkg::cell_ctrl_t        ctrl,
	input  logic                       prev_cond,
	input  logic [spq_pkg::VAL_W-1:0]  prev_value,
	input  logic [spq_pkg::PRIO_W-1:0] prev_prio,
	input  logic [spq_pkg::VAL_W-1:0]  nbr_value,
	input  logic [spq_pkg::PRIO_W-1:0] nbr_prio,
	output logic                       cond,
	output logic [spq_pkg::VAL_W-1:0]  value_q,
	output logic [spq_pkg::PRIO_W-1:0] prio_q,
	output logic [spq_pkg::VAL_W-1:0]  value_d,
	output logic [spq_pkg::PRIO_W-1:0] prio_d
);

	// New entry belongs here or earlier when this slot is free or weaker
	assign cond = !entry_valid || (prio_q < ctrl.prio);

	always_comb begin
		value_d = value_q;
		prio_d  = prio_q;
		if (ctrl.ins) begin
			if (prev_cond) begin
				value_d = prev_value;
				prio_d  = prev_prio;
			end else if (cond) begin
				value_d = ctrl.value;
				prio_d  = ctrl.prio;
			end
		end else if (ctrl.rem) begin
			value_d = nbr_value;
			prio_d  = nbr_prio;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		prio_q  <= prio_d;
	end

endmodule

>>> src/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: cell chain, count and result register.
//
//  channel | words                                         | handshake
//  --------+-----------------------------------------------+------------------
//  in      | mode, value, prio                             | in_valid/in_stall
//  out     | status, removed_value, head_value, head_prio, | out_valid/out_stall
//          | is_empty, count                               |
//
// One word is taken per cycle while the result is not stalled; its result appears in the cycle after acceptance.
// Every cell compares and shifts in parallel, so the chain length does not
// set the rate; the result register alone paces the input.
// Reset clears the count and the result valid; cell contents stay undefined
// and are masked by the count.
// A stalled result holds the input off; a result being taken frees it in
// the same cycle.
module sorted_priority_queue_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic signed [spq_pkg::VAL_W-1:0]  value,
	input  logic [spq_pkg::PRIO_W-1:0]        prio,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [spq_pkg::VAL_W-1:0]  removed_value,
	output logic signed [spq_pkg::VAL_W-1:0]  head_value,
	output logic [spq_pkg::PRIO_W-1:0]        head_prio,
	output logic                              is_empty,
	output logic [spq_pkg::COUNT_OUT_W-1:0]   count
);

	localparam int CAP = spq_pkg::CAPACITY;

	logic                            in_acc;
	logic                            full;
	logic                            empty;
	logic [spq_pkg::CNT_W-1:0]       cnt_q;
	logic [spq_pkg::CNT_W-1:0]       cnt_d;
	spq_pkg::cell_ctrl_t             ctrl;
	spq_pkg::status_t                status_d;

	logic                            cond    [CAP];
	logic [spq_pkg::VAL_W-1:0]       val_q   [CAP];
	logic [spq_pkg::PRIO_W-1:0]      pri_q   [CAP];
	logic [spq_pkg::VAL_W-1:0]       val_d   [CAP];
	logic [spq_pkg::PRIO_W-1:0]      pri_d   [CAP];

	logic                            out_valid_q;
	spq_pkg::status_t                status_q;
	logic [spq_pkg::VAL_W-1:0]       removed_q;
	logic [spq_pkg::VAL_W-1:0]       head_value_q;
	logic [spq_pkg::PRIO_W-1:0]      head_prio_q;
	logic                            is_empty_q;
	logic [spq_pkg::COUNT_OUT_W-1:0] count_q;

	// Accept whenever the result register is free or being emptied
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign full  = (cnt_q == spq_pkg::CNT_W'(CAP));
	assign empty = (cnt_q == '0);

	// Drop inserts into a full queue and removes from an empty one
	always_comb begin
		ctrl.ins   = in_acc && (mode == spq_pkg::MODE_INSERT) && !full;
		ctrl.rem   = in_acc && (mode == spq_pkg::MODE_REMOVE) && !empty;
		ctrl.value = $unsigned(value);
		ctrl.prio  = prio;
		if (mode == spq_pkg::MODE_INSERT)
			status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
		else
			status_d = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
		if (ctrl.ins)
			cnt_d = cnt_q + 1'b1;
		else if (ctrl.rem)
			cnt_d = cnt_q - 1'b1;
		else
			cnt_d = cnt_q;
	end

	// Cell chain; slot i holds a live entry while i is below the count
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic                       live;
		logic                       pc;
		logic [spq_pkg::VAL_W-1:0]  pv;
		logic [spq_pkg::PRIO_W-1:0] pp;
		logic [spq_pkg::VAL_W-1:0]  nv;
		logic [spq_pkg::PRIO_W-1:0] np;

		assign live = (spq_pkg::CNT_W'(i) < cnt_q);

		if (i == 0) begin : g_head
			assign pc = 1'b0;
			assign pv = ctrl.value;
			assign pp = ctrl.prio;
		end else begin : g_body
			assign pc = cond[i-1];
			assign pv = val_q[i-1];
			assign pp = pri_q[i-1];
		end

		if (i == CAP - 1) begin : g_tail
			assign nv = val_q[i];
			assign np = pri_q[i];
		end else begin : g_inner
			assign nv = val_q[i+1];
			assign np = pri_q[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.entry_valid (live),
			.ctrl        (ctrl),
			.prev_cond   (pc),
			.prev_value  (pv),
			.prev_prio   (pp),
			.nbr_value   (nv),
			.nbr_prio    (np),
			.cond        (cond[i]),
			.value_q     (val_q[i]),
			.prio_q      (pri_q[i]),
			.value_d     (val_d[i]),
			.prio_d      (pri_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (in_acc)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Result word: head and count as they stand after the operation
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q     <= status_d;
			removed_q    <= ctrl.rem ? val_q[0] : '0;
			head_value_q <= (cnt_d != '0) ? val_d[0] : '0;
			head_prio_q  <= (cnt_d != '0) ? pri_d[0] : '0;
			is_empty_q   <= (cnt_d == '0);
			count_q      <= spq_pkg::COUNT_OUT_W'(cnt_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = $signed(removed_q);
	assign head_value    = $signed(head_value_q);
	assign head_prio     = head_prio_q;
	assign is_empty      = is_empty_q;
	assign count         = count_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= spq_pkg::CNT_W'(CAP))
		else $error("occupancy above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (mode == spq_pkg::MODE_INSERT) && full
		|=> out_valid && (status == spq_pkg::ST_FULL) && $stable(cnt_q))
		else $error("insert into full queue not dropped");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted word gave no result");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (is_empty_q == (count_q == '0)))
		else $error("empty flag disagrees with count");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= spq_pkg::CNT_W'(2)) |-> (pri_q[0] >= pri_q[1]))
		else $error("head entry out of order");
`endif

endmodule

>>> dv/tb_sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue top level.
module tb_sorted_priority_queue_top;

	// Cycle budget for the whole run. The slowest correct run is about 800 words,
	// each with the longest sender gap and the longest receiver stall, plus one
	// long hold-off. The limit is several times the length of that run.
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;  // long receiver hold-off used for back-pressure
	localparam int MAX_REPORTS = 10;

	// One stored entry of the shadow queue.
	typedef struct packed {
		logic signed [spq_pkg::VAL_W-1:0] val;
		logic [spq_pkg::PRIO_W-1:0]       pr;
	} entry_t;

	// One result word as the block reports it.
	typedef struct packed {
		logic [1:0]                        status;
		logic signed [spq_pkg::VAL_W-1:0]  removed_value;
		logic signed [spq_pkg::VAL_W-1:0]  head_value;
		logic [spq_pkg::PRIO_W-1:0]        head_prio;
		logic                              is_empty;
		logic [spq_pkg::COUNT_OUT_W-1:0]   count;
	} queue_outcome_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic                                mode;
	logic signed [spq_pkg::VAL_W-1:0]    value;
	logic [spq_pkg::PRIO_W-1:0]          prio;
	logic                                out_valid;
	logic                                out_stall;
	logic [1:0]                          status;
	logic signed [spq_pkg::VAL_W-1:0]    removed_value;
	logic signed [spq_pkg::VAL_W-1:0]    head_value;
	logic [spq_pkg::PRIO_W-1:0]          head_prio;
	logic                                is_empty;
	logic [spq_pkg::COUNT_OUT_W-1:0]     count;

	// Shadow copy of the queue contents, head at index 0, and the outcomes
	// still owed by the block, oldest first.
	entry_t         shadow_entries[$];
	queue_outcome_t queue_outcomes[$];

	// Idling controls shared between the stimulus, the receiver and the tests.
	bit tx_gaps;
	bit rx_bursts;
	bit hold_request;

	int mismatches;
	int results_seen;
	int inserts_done;
	int removes_done;
	int inserts_dropped;
	int removes_on_empty;
	int peak_count;
	int cycles;

	sorted_priority_queue_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.value         (value),
		.prio          (prio),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.removed_value (removed_value),
		.head_value    (head_value),
		.head_prio     (head_prio),
		.is_empty      (is_empty),
		.count         (count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out what the block should report for one word and advance the
	// shadow queue. Inserts land behind every entry of equal or higher
	// priority, which keeps equal priorities in arrival order.
	function automatic queue_outcome_t predict_queue_op(logic m,
			logic signed [spq_pkg::VAL_W-1:0] v, logic [spq_pkg::PRIO_W-1:0] p);
		queue_outcome_t r;
		entry_t         e;
		int             pos;
		r = '0;
		r.status = spq_pkg::ST_DONE;
		if (m == spq_pkg::MODE_INSERT) begin
			if (shadow_entries.size() >= spq_pkg::CAPACITY) begin
				r.status = spq_pkg::ST_FULL;
				inserts_dropped++;
			end else begin
				e.val = v;
				e.pr  = p;
				pos = shadow_entries.size();
				while (pos > 0 && shadow_entries[pos - 1].pr < p)
					pos--;
				shadow_entries.insert(pos, e);
				inserts_done++;
			end
		end else begin
			if (shadow_entries.size() == 0) begin
				r.status = spq_pkg::ST_EMPTY;
				removes_on_empty++;
			end else begin
				r.removed_value = shadow_entries[0].val;
				void'(shadow_entries.pop_front());
				removes_done++;
			end
		end
		if (shadow_entries.size() != 0) begin
			r.head_value = shadow_entries[0].val;
			r.head_prio  = shadow_entries[0].pr;
		end
		r.is_empty = (shadow_entries.size() == 0);
		r.count    = spq_pkg::COUNT_OUT_W'(shadow_entries.size());
		if (shadow_entries.size() > peak_count)
			peak_count = shadow_entries.size();
		return r;
	endfunction

	// Offer one word and hold it until the block takes it. Valid stays high on
	// return so that back-to-back words need no gap; a gap, when one is drawn,
	// drops valid first.
	task automatic send_word(logic m, logic signed [spq_pkg::VAL_W-1:0] v,
			logic [spq_pkg::PRIO_W-1:0] p);
		int unsigned gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		prio     <= p;
		do
			@(posedge clk);
		while (in_stall);
		queue_outcomes.push_back(predict_queue_op(m, v, p));
	endtask

	// Drop valid and wait until every owed result has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (queue_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Priorities drawn half the time from a narrow band so that ties are common.
	function automatic logic [spq_pkg::PRIO_W-1:0] draw_prio();
		if ($urandom_range(0, 1) == 0)
			return spq_pkg::PRIO_W'($urandom_range(0, 3));
		return spq_pkg::PRIO_W'($urandom);
	endfunction

	// Receiver: random stall bursts, and on request one long hold-off counted
	// here so that the sender keeps offering words into a full block.
	initial begin
		int unsigned burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (burst - 1) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker: compare each word taken with the oldest owed outcome.
	always @(posedge clk) begin
		queue_outcome_t got;
		queue_outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, removed_value, head_value, head_prio, is_empty, count};
			results_seen++;
			if (queue_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing owed: status %0d count %0d",
						$time, got.status, got.count);
			end else begin
				want = queue_outcomes.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: mismatch (expected/actual) status %0d/%0d removed %0d/%0d",
							$time, want.status, got.status,
							want.removed_value, got.removed_value);
						$display("    head %0d/%0d prio %0d/%0d empty %0b/%0b count %0d/%0d",
							want.head_value, got.head_value, want.head_prio, got.head_prio,
							want.is_empty, got.is_empty, want.count, got.count);
					end
				end
			end
		end
	end

	// Watchdog: end the run if it goes past the cycle budget.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("end of test: mismatches");
		$finish;
	end

	// Extremes of value and priority, ties at both ends of the priority range,
	// remove on an empty queue before and after, and the empty head fields.
	task automatic test_directed();
		send_word(spq_pkg::MODE_REMOVE, 32'sh1234_5678, 8'hff);
		send_word(spq_pkg::MODE_INSERT, 32'sh8000_0000, 8'h00);
		send_word(spq_pkg::MODE_INSERT, 32'sh7fff_ffff, 8'hff);
		send_word(spq_pkg::MODE_INSERT, -32'sd1, 8'hff);
		send_word(spq_pkg::MODE_INSERT, 32'sd1, 8'h00);
		send_word(spq_pkg::MODE_INSERT, 32'sd0, 8'h80);
		send_word(spq_pkg::MODE_INSERT, 32'sh5555_5555, 8'h55);
		send_word(spq_pkg::MODE_INSERT, 32'shaaaa_aaaa, 8'haa);
		repeat (8)
			send_word(spq_pkg::MODE_REMOVE, $urandom, spq_pkg::PRIO_W'($urandom));
		send_word(spq_pkg::MODE_INSERT, 32'sh0000_ffff, 8'h01);
		send_word(spq_pkg::MODE_REMOVE, 32'sh0, 8'h0);
	endtask

	// Fill past capacity so the last inserts are dropped, then empty it and
	// remove twice more than it holds.
	task automatic test_fill_and_drain();
		repeat (spq_pkg::CAPACITY + 2)
			send_word(spq_pkg::MODE_INSERT, $urandom, draw_prio());
		repeat (spq_pkg::CAPACITY + 2)
			send_word(spq_pkg::MODE_REMOVE, $urandom, spq_pkg::PRIO_W'($urandom));
	endtask

	// Hold the receiver off for a long stretch while words keep coming, so
	// the block fills and stalls its input; then let it all drain.
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (40)
			send_word(($urandom_range(0, 3) == 0) ? spq_pkg::MODE_REMOVE
				: spq_pkg::MODE_INSERT, $urandom, draw_prio());
		tx_gaps = 1'b1;
	endtask

	// Random mix in segments, each with its own insert bias, so that the
	// occupancy swings between empty and full.
	task automatic test_random_mix();
		int unsigned bias;
		repeat (10) begin
			case ($urandom_range(0, 2))
				0: bias = 85;
				1: bias = 50;
				default: bias = 20;
			endcase
			repeat (50)
				send_word(($urandom_range(1, 100) <= bias) ? spq_pkg::MODE_INSERT
					: spq_pkg::MODE_REMOVE, $urandom, draw_prio());
		end
	endtask

	// Full-rate stream with no idling on either side.
	task automatic test_steady_stream();
		tx_gaps   = 1'b0;
		rx_bursts = 1'b0;
		repeat (100)
			send_word(($urandom_range(1, 100) <= 60) ? spq_pkg::MODE_INSERT
				: spq_pkg::MODE_REMOVE, $urandom, draw_prio());
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = spq_pkg::MODE_INSERT;
		value        = '0;
		prio         = '0;
		tx_gaps      = 1'b1;
		rx_bursts    = 1'b1;
		hold_request = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		drain_results();
		test_fill_and_drain();
		drain_results();
		test_backpressure();
		drain_results();
		test_random_mix();
		test_steady_stream();

		// Wait out the owed results, then idle on to catch anything stray.
		drain_results();
		repeat (10) @(posedge clk);

		$display("covered %0d inserts, %0d removes, %0d dropped on full, %0d removes on empty",
			inserts_done, removes_done, inserts_dropped, removes_on_empty);
		$display("checked %0d results, peak occupancy %0d of %0d",
			results_seen, peak_count, spq_pkg::CAPACITY);
		if (mismatches == 0 && queue_outcomes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never came", mismatches,
				queue_outcomes.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
dv/tb_sorted_priority_queue_top.sv
